@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers; they compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge outside of reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check a property on every rising edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

@@ sv/stsb_pkg.sv @@
// ----------------------------------------------------------------------------
// stsb_pkg
// Shared constants and types of the sorted table search block.
// ----------------------------------------------------------------------------
`default_nettype none

package stsb_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int LEN_W       = $clog2(TABLE_DEPTH + 1);
    localparam int DATA_W      = 32;

    // Item commands
    typedef enum logic [0:0] {
        CMD_WRITE  = 1'b0,
        CMD_SEARCH = 1'b1
    } t_cmd;

    // Table memory access from the controller
    typedef struct packed {
        logic                     we;
        logic [IDX_W-1:0]         waddr;
        logic signed [DATA_W-1:0] wdata;
        logic                     re;
        logic [IDX_W-1:0]         raddr;
    } t_ram_req;

endpackage

`default_nettype wire

@@ sv/sorted_table_binary_search_top.sv @@
// ----------------------------------------------------------------------------
// sorted_table_binary_search_top
// Binary search over a signed 32-bit table the user keeps sorted ascending.
// ----------------------------------------------------------------------------
// A write word stores one entry and gives no result. A search word on a
// non-empty table probes the table memory once per cycle, halving the
// bounds around the midpoint: the block stalls its input while it probes,
// between 1 and floor(log2(depth))+1 probes (1 to 5 for 16 entries), and a
// search of an empty table finishes without a probe. The single read port
// of the table memory and its registered read data set the pace. A result
// is registered and may wait for the consumer while the next word is taken;
// a search that finishes while an earlier result still waits keeps the
// input stalled until that result is taken. The block does not sort the
// entries. Entries must be written before a search reads them.
`default_nettype none

`include "assert_macros.svh"

module sorted_table_binary_search_top
    import stsb_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // Input words
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic                     i_command,
    input  wire logic [IDX_W-1:0]         i_entry_index,
    input  wire logic signed [DATA_W-1:0] i_entry_value,
    input  wire logic signed [DATA_W-1:0] i_search_key,
    // Result words
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic                          o_found,
    output logic [IDX_W-1:0]              o_position,
    // Table length register write
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [LEN_W-1:0]         i_cfg_data
);

    logic [LEN_W-1:0]          r_table_length;
    t_ram_req                  ram_req;
    logic signed [DATA_W-1:0]  ram_rdata;

    // Hold the table length register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_length <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_table_length <= i_cfg_data;
        end
    end

    stsb_search_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_entry_index  (i_entry_index),
        .i_entry_value  (i_entry_value),
        .i_search_key   (i_search_key),
        .i_table_length (r_table_length),
        .o_ram_req      (ram_req),
        .i_ram_rdata    (ram_rdata),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_found        (o_found),
        .o_position     (o_position)
    );

    stsb_table_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (DATA_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    // A miss always reports position zero
    `ASSERT_CLK(a_miss_pos_zero, i_clk, i_rst_n, (o_out_valid && !o_found) |-> (o_position == '0), "miss with nonzero position")

    // A hit lies inside the table in use
    `ASSERT_CLK(a_hit_in_range, i_clk, i_rst_n, (o_out_valid && o_found) |-> ({1'b0, o_position} < r_table_length), "hit beyond table length")

    // The table memory is never written and probed in one cycle
    `ASSERT_CLK(a_ram_excl, i_clk, i_rst_n, !(ram_req.we && ram_req.re), "table write during a probe")

    // A write word never produces a result
    `ASSERT_CLK(a_write_no_result, i_clk, i_rst_n, (i_in_valid && !o_in_stall && (i_command == CMD_WRITE) && !o_out_valid) |=> !o_out_valid, "result after a write")

endmodule

`default_nettype wire

@@ sv/stsb_table_ram.sv @@
// ----------------------------------------------------------------------------
// stsb_table_ram
// Single-port-write, single-port-read table memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module stsb_table_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read one entry, data valid the next cycle
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ sv/stsb_search_ctrl.sv @@
// ----------------------------------------------------------------------------
// stsb_search_ctrl
// Takes write and search words, drives the table memory and runs the binary
// search one probe per cycle; holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module stsb_search_ctrl
    import stsb_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic                     i_command,
    input  wire logic [IDX_W-1:0]         i_entry_index,
    input  wire logic signed [DATA_W-1:0] i_entry_value,
    input  wire logic signed [DATA_W-1:0] i_search_key,
    input  wire logic [LEN_W-1:0]         i_table_length,
    output t_ram_req                      o_ram_req,
    input  wire logic signed [DATA_W-1:0] i_ram_rdata,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic                          o_found,
    output logic [IDX_W-1:0]              o_position
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_HOLD
    } t_state;

    t_state                    r_state;
    logic [LEN_W-1:0]          r_lo;
    logic [LEN_W-1:0]          r_end;
    logic [IDX_W-1:0]          r_mid;
    logic signed [DATA_W-1:0]  r_key;
    logic                      r_hit;
    logic [IDX_W-1:0]          r_pos;
    logic                      r_out_valid;
    logic                      r_found;
    logic [IDX_W-1:0]          r_position;

    logic                      in_accept;
    logic                      out_free;
    logic [LEN_W-1:0]          len_clamped;
    logic [IDX_W-1:0]          start_mid;
    logic                      key_lt;
    logic                      key_gt;
    logic                      hit_now;
    logic [LEN_W-1:0]          n_lo;
    logic [LEN_W-1:0]          n_end;
    logic [IDX_W-1:0]          n_mid;
    logic                      more;
    logic                      done;
    logic                      res_found;
    logic [IDX_W-1:0]          res_pos;

    // Midpoint of the half-open range [lo, end), end above lo
    function automatic logic [IDX_W-1:0] mid_of(input logic [LEN_W-1:0] lo,
                                                input logic [LEN_W-1:0] hi_ex);
        logic [LEN_W:0] sum;
        sum    = {1'b0, lo} + {1'b0, hi_ex} - (LEN_W+1)'(1);
        mid_of = IDX_W'(sum >> 1);
    endfunction

    // Handshake
    assign in_accept  = i_in_valid && (r_state == ST_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE);

    // Clamp the length to the table depth
    assign len_clamped = (i_table_length > LEN_W'(TABLE_DEPTH))
                         ? LEN_W'(TABLE_DEPTH) : i_table_length;
    assign start_mid   = mid_of('0, len_clamped);

    // Compare the probed entry and narrow the bounds
    always_comb begin
        key_lt  = (r_key < i_ram_rdata);
        key_gt  = (r_key > i_ram_rdata);
        hit_now = !key_lt && !key_gt;
        n_lo    = key_lt ? r_lo : (LEN_W'(r_mid) + LEN_W'(1));
        n_end   = key_lt ? LEN_W'(r_mid) : r_end;
        more    = !hit_now && (n_lo < n_end);
        n_mid   = mid_of(n_lo, n_end);
    end

    // Completion and result selection
    always_comb begin
        done      = 1'b0;
        res_found = 1'b0;
        res_pos   = '0;
        unique case (r_state)
            ST_IDLE: begin
                done = in_accept && (i_command == CMD_SEARCH) && (len_clamped == '0);
            end
            ST_SEARCH: begin
                done      = !more;
                res_found = hit_now;
                res_pos   = hit_now ? r_mid : '0;
            end
            ST_HOLD: begin
                done      = 1'b1;
                res_found = r_hit;
                res_pos   = r_pos;
            end
            default: begin
                done = 1'b0;
            end
        endcase
    end

    // Table memory requests
    always_comb begin
        o_ram_req       = '0;
        o_ram_req.waddr = i_entry_index;
        o_ram_req.wdata = i_entry_value;
        o_ram_req.we    = in_accept && (i_command == CMD_WRITE);
        if (r_state == ST_SEARCH) begin
            o_ram_req.re    = more;
            o_ram_req.raddr = n_mid;
        end else begin
            o_ram_req.re    = in_accept && (i_command == CMD_SEARCH)
                              && (len_clamped != '0);
            o_ram_req.raddr = start_mid;
        end
    end

    // State, bounds and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // Load a finished result when the output register is free,
            // else drop a word once it is taken
            if (done && out_free) begin
                r_out_valid <= 1'b1;
                r_found     <= res_found;
                r_position  <= res_pos;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (done) begin
                r_hit <= res_found;
                r_pos <= res_pos;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_accept && (i_command == CMD_SEARCH)) begin
                        r_key <= i_search_key;
                        r_lo  <= '0;
                        r_end <= len_clamped;
                        r_mid <= start_mid;
                        if (len_clamped != '0) begin
                            r_state <= ST_SEARCH;
                        end else if (!out_free) begin
                            r_state <= ST_HOLD;
                        end
                    end
                end
                ST_SEARCH: begin
                    if (more) begin
                        r_lo  <= n_lo;
                        r_end <= n_end;
                        r_mid <= n_mid;
                    end else if (out_free) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_state <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_position  = r_position;

endmodule

`default_nettype wire

@@ tb/tb_sorted_table_binary_search_top.sv @@
// ----------------------------------------------------------------------------
// tb_sorted_table_binary_search_top
// Self-checking bench for the sorted table binary search block.
// ----------------------------------------------------------------------------
// A tracker class keeps its own copy of the table and the length register.
// It predicts the found flag and position of every accepted search word and
// compares them with the result words in order. A short directed sequence
// covers the field extremes, an empty table, duplicates, keys that are not
// present, a length beyond the depth and an unsorted table. Random phases
// follow. Each phase sets a new length while the block is idle, mostly
// reloads a sorted table, then issues searches half of whose keys are drawn
// from the table. Both sides idle at random. One phase runs without idling,
// and one phase holds the result side off long enough to back up the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import stsb_pkg::*;

typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] position;
} t_lookup;

class lookup_tracker;
    logic signed [DATA_W-1:0] entries[TABLE_DEPTH];
    logic [LEN_W-1:0]         length_reg;
    t_lookup                  awaited[$];
    int                       failures;

    function new();
        length_reg = '0;
        failures   = 0;
    endfunction

    function void set_length(logic [LEN_W-1:0] len);
        length_reg = len;
    endfunction

    // Store a write word, or predict the outcome of a search word
    function void take_word(t_cmd cmd, logic [IDX_W-1:0] idx,
                            logic signed [DATA_W-1:0] value,
                            logic signed [DATA_W-1:0] key);
        int      lo;
        int      hi;
        int      mid;
        int      span;
        t_lookup res;
        if (cmd == CMD_WRITE) begin
            entries[idx] = value;
            return;
        end
        // Clamp a length beyond the depth
        span = (length_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(length_reg);
        res.found    = 1'b0;
        res.position = '0;
        lo = 0;
        hi = span - 1;
        // Halve the bounds; the first matching probe wins
        while (lo <= hi && !res.found) begin
            mid = (lo + hi) / 2;
            if (key < entries[mid]) begin
                hi = mid - 1;
            end else if (key > entries[mid]) begin
                lo = mid + 1;
            end else begin
                res.found    = 1'b1;
                res.position = IDX_W'(mid);
            end
        end
        awaited.push_back(res);
    endfunction

    // Compare one result word with the oldest predicted lookup
    function void check_lookup(logic found, logic [IDX_W-1:0] position);
        t_lookup want;
        if (awaited.size() == 0) begin
            $error("result word with no search pending: found=%0b position=%0d",
                   found, position);
            failures++;
            return;
        end
        want = awaited.pop_front();
        if (found !== want.found) begin
            $error("found mismatch: expected %0b, actual %0b", want.found, found);
            failures++;
        end
        if (position !== want.position) begin
            $error("position mismatch: expected %0d, actual %0d",
                   want.position, position);
            failures++;
        end
    endfunction
endclass

module tb_sorted_table_binary_search_top;

    localparam int ITEM_TARGET   = 1550;
    localparam int SETTLE_CYCLES = 10;
    localparam int HOLD_CYCLES   = 150;
    localparam int STUCK_LIMIT   = 3000;
    localparam int QUIET_PHASE   = 4;
    localparam int HOLD_PHASE    = 6;

    logic                     clk         = 1'b0;
    logic                     rst_n       = 1'b0;
    logic                     in_valid    = 1'b0;
    logic                     in_stall;
    t_cmd                     command     = CMD_WRITE;
    logic [IDX_W-1:0]         entry_index = '0;
    logic signed [DATA_W-1:0] entry_value = '0;
    logic signed [DATA_W-1:0] search_key  = '0;
    logic                     out_valid;
    logic                     out_stall   = 1'b0;
    logic                     found;
    logic [IDX_W-1:0]         position;
    logic                     cfg_valid   = 1'b0;
    logic                     cfg_ready;
    logic [LEN_W-1:0]         cfg_data    = '0;

    bit                       quiet        = 1'b0;
    bit                       hold_request = 1'b0;
    int                       items_sent   = 0;
    int                       stuck_cycles = 0;
    lookup_tracker            tracker      = new();

    // Sorted table for the directed part, with duplicates and both extremes
    int directed_vals[TABLE_DEPTH] = '{
        32'sh80000000, -1000, -5, -5, -5, 0, 3, 7,
        7, 100, 1000, 65536, 1000000, 32'sh40000000, 32'sh7FFFFFFE, 32'sh7FFFFFFF
    };

    // Lengths of the first random phases
    int length_list[6] = '{0, 1, 16, 31, 17, 2};

    sorted_table_binary_search_top DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_command     (command),
        .i_entry_index (entry_index),
        .i_entry_value (entry_value),
        .i_search_key  (search_key),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_found       (found),
        .o_position    (position),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Offer one input word after a random gap and hold it until accepted
    task automatic send_word(t_cmd cmd, logic [IDX_W-1:0] idx,
                             logic signed [DATA_W-1:0] value,
                             logic signed [DATA_W-1:0] key);
        while (!quiet && $urandom_range(0, 99) < 31) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        command     <= cmd;
        entry_index <= idx;
        entry_value <= value;
        search_key  <= key;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        tracker.take_word(cmd, idx, value, key);
        items_sent++;
    endtask

    task automatic send_search(logic signed [DATA_W-1:0] key);
        send_word(CMD_SEARCH, IDX_W'($urandom), DATA_W'($urandom), key);
    endtask

    task automatic send_entry(int idx, logic signed [DATA_W-1:0] value);
        send_word(CMD_WRITE, IDX_W'(idx), value, DATA_W'($urandom));
    endtask

    // Drop valid and wait until every predicted lookup has come back
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.awaited.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the length register once the block is idle
    task automatic write_length(logic [LEN_W-1:0] len);
        drain_results();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        tracker.set_length(len);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Write a fresh sorted table of random content
    task automatic load_sorted_table(int flavor);
        int vals[$];
        int v;
        int j;
        bit descending;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            unique case (flavor)
                0: v = $urandom;
                1: v = $urandom_range(0, 20) - 10;
                2: v = 32'sh80000000 + int'($urandom_range(0, 50));
                default: v = 32'sh7FFFFFFF - int'($urandom_range(0, 50));
            endcase
            vals.push_back(v);
        end
        vals.sort();
        descending = $urandom_range(0, 1);
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            j = descending ? TABLE_DEPTH - 1 - i : i;
            send_entry(j, vals[j]);
        end
    endtask

    // Keys present in the table half the time, then neighbors, extremes and noise
    function automatic logic signed [DATA_W-1:0] pick_key();
        int                       sel;
        logic signed [DATA_W-1:0] base;
        sel  = $urandom_range(0, 99);
        base = tracker.entries[$urandom_range(0, TABLE_DEPTH - 1)];
        if (sel < 50) return base;
        if (sel < 65) return sel[0] ? base + 1 : base - 1;
        if (sel < 75) return sel[0] ? 32'sh7FFFFFFF : 32'sh80000000;
        return DATA_W'($urandom);
    endfunction

    // Result side: random stall, or a long hold-off on request
    initial begin
        forever begin
            @(negedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_stall <= !quiet && ($urandom_range(0, 99) < 31);
        end
    end

    // Check every accepted result word
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            tracker.check_lookup(found, position);
        end
    end

    // End the run when nothing moves for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("sorted_table_binary_search_top verification failed");
            $finish;
        end
    end

    initial begin
        logic [LEN_W-1:0] len;
        int               n_words;
        int               phase;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty table, then a sorted table with duplicates
        send_search(32'sd0);
        for (int i = 0; i < TABLE_DEPTH; i++) send_entry(i, directed_vals[i]);
        write_length(LEN_W'(31));
        send_search(32'sh80000000);
        send_search(32'sh7FFFFFFF);
        send_search(-32'sd5);
        send_search(32'sd7);
        send_search(32'sd50);
        send_search(32'sh7FFFFFFE);
        // Break the order and search across the damaged entry
        send_entry(7, -32'sd100000);
        send_search(-32'sd100000);

        // Random phases
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            if (phase < 6) begin
                len = LEN_W'(length_list[phase]);
            end else if (phase == HOLD_PHASE || $urandom_range(0, 3) != 0) begin
                len = LEN_W'(16);
            end else begin
                len = LEN_W'($urandom_range(0, 31));
            end
            write_length(len);
            quiet = (phase == QUIET_PHASE);
            if (phase == HOLD_PHASE) hold_request = 1'b1;
            if ($urandom_range(0, 3) != 0) load_sorted_table($urandom_range(0, 3));
            n_words = $urandom_range(40, 90);
            repeat (n_words) begin
                if ($urandom_range(0, 99) < 8) begin
                    send_entry($urandom_range(0, TABLE_DEPTH - 1), DATA_W'($urandom));
                end else begin
                    send_search(pick_key());
                end
            end
            phase++;
        end

        quiet = 1'b0;
        drain_results();
        repeat (20) @(posedge clk);
        if (tracker.failures == 0) begin
            $display("sorted_table_binary_search_top verification clean");
        end else begin
            $display("sorted_table_binary_search_top verification failed");
        end
        $finish;
    end

endmodule
